>>> rtl/rv32x_pkg.sv
// ----------------------------------------------------------------------------
// rv32x_pkg
// Shared types, opcodes and status codes for the rv32i/zicsr executor.
// ----------------------------------------------------------------------------
package rv32x_pkg;

    localparam logic [31:0] RESET_PC = 32'h8000_0000;
    localparam int          NUM_REGS = 32;
    localparam int          NUM_CSRS = 7;

    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JAL    = 7'h6f;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_FENCE  = 7'h0f;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    localparam logic [31:0] INST_EBREAK = 32'h0010_0073;

    localparam logic [2:0] ST_EXEC    = 3'd0;
    localparam logic [2:0] ST_HALT    = 3'd1;
    localparam logic [2:0] ST_INVALID = 3'd2;
    localparam logic [2:0] ST_STOPPED = 3'd3;
    localparam logic [2:0] ST_ORDER   = 3'd4;

    localparam logic       CMD_INST = 1'b0;
    localparam logic       CMD_DATA = 1'b1;

    typedef struct packed {
        logic        en;
        logic [4:0]  idx;
        logic [31:0] data;
    } rf_wr_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] next_pc;
        logic        mem_valid;
        logic        mem_write;
        logic [1:0]  mem_size;
        logic [31:0] mem_addr;
        logic [31:0] mem_wdata;
        logic        rd_write;
        logic [4:0]  rd_index;
        logic [31:0] rd_value;
        logic        load_waiting;
    } res_t;

    // csr number to storage slot; valid flag in the top bit
    function automatic logic [3:0] csr_slot(input logic [11:0] num);
        logic [3:0] s;
        case (num)
            12'h300: s = 4'b1000;
            12'h304: s = 4'b1001;
            12'h305: s = 4'b1010;
            12'h340: s = 4'b1011;
            12'h341: s = 4'b1100;
            12'h342: s = 4'b1101;
            12'h344: s = 4'b1110;
            default: s = 4'b0000;
        endcase
        return s;
    endfunction

endpackage

>>> rtl/rv32x_regfile.sv
// ----------------------------------------------------------------------------
// rv32x_regfile
// Synchronous register file memory with reset valid bits and write forwarding.
// ----------------------------------------------------------------------------
module rv32x_regfile (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  rd_en,
    input  logic [$clog2(rv32x_pkg::NUM_REGS)-1:0] rs1,
    input  logic [$clog2(rv32x_pkg::NUM_REGS)-1:0] rs2,
    input  rv32x_pkg::rf_wr_t                     wr,
    output logic [31:0]                           a,
    output logic [31:0]                           b
);
    import rv32x_pkg::*;

    localparam int AW = $clog2(NUM_REGS);

    logic [31:0]         mem [NUM_REGS];
    logic [31:0]         q1_reg, q2_reg, fwd_reg;
    logic [NUM_REGS-1:0] vld_reg;
    logic                v1_reg, v2_reg, hit1_reg, hit2_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.idx[AW-1:0]] <= wr.data;
        if (rd_en)
        begin
            q1_reg  <= mem[rs1];
            q2_reg  <= mem[rs2];
            fwd_reg <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            hit1_reg <= 1'b0;
            hit2_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
                vld_reg[wr.idx[AW-1:0]] <= 1'b1;
            if (rd_en)
            begin
                v1_reg   <= vld_reg[rs1];
                v2_reg   <= vld_reg[rs2];
                // same-edge write is not yet in the array
                hit1_reg <= wr.en && (wr.idx[AW-1:0] == rs1);
                hit2_reg <= wr.en && (wr.idx[AW-1:0] == rs2);
            end
        end
    end

    assign a = hit1_reg ? fwd_reg : (v1_reg ? q1_reg : 32'd0);
    assign b = hit2_reg ? fwd_reg : (v2_reg ? q2_reg : 32'd0);

endmodule

>>> rtl/rv32x_exec.sv
// ----------------------------------------------------------------------------
// rv32x_exec
// Decode and execute of one item, with pc, csr and run-state registers.
// ----------------------------------------------------------------------------
module rv32x_exec (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                cmd,
    input  logic [31:0]         inst,
    input  logic [31:0]         ldata,
    input  logic [31:0]         a,
    input  logic [31:0]         b,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_pc,
    output rv32x_pkg::rf_wr_t   wr,
    output rv32x_pkg::res_t     res
);
    import rv32x_pkg::*;

    logic [31:0] pc_reg, pc_next;
    logic [31:0] csr_reg [NUM_CSRS];
    logic        halted_reg, halted_next, aborted_reg, aborted_next;
    logic        lpend_reg, lpend_next;
    logic [4:0]  ldest_reg, ldest_next;
    logic [2:0]  lkind_reg, lkind_next;
    logic        csr_we;
    logic [2:0]  csr_idx;
    logic [31:0] csr_wval;

    logic [6:0]  op;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] ii, si, bi, ji, npc, r, old, opnd;
    logic [3:0]  slot;
    logic        bad, want, taken, upd;

    always_comb
    begin
        op   = inst[6:0];
        rd   = inst[11:7];
        f3   = inst[14:12];
        rs1  = inst[19:15];
        rs2  = inst[24:20];
        f7   = inst[31:25];
        ii   = {{20{inst[31]}}, inst[31:20]};
        si   = {{20{inst[31]}}, inst[31:25], inst[11:7]};
        bi   = {{19{inst[31]}}, inst[31], inst[7], inst[30:25], inst[11:8], 1'b0};
        ji   = {{11{inst[31]}}, inst[31], inst[19:12], inst[20], inst[30:21], 1'b0};
        npc  = pc_reg + 32'd4;
        r    = '0;
        old  = '0;
        opnd = '0;
        slot = '0;
        bad  = 1'b0;
        want = 1'b0;
        taken = 1'b0;
        upd  = 1'b0;
        res  = '0;
        res.status   = ST_EXEC;
        halted_next  = halted_reg;
        aborted_next = aborted_reg;
        lpend_next   = lpend_reg;
        ldest_next   = ldest_reg;
        lkind_next   = lkind_reg;
        csr_we   = 1'b0;
        csr_idx  = '0;
        csr_wval = '0;
        wr = '0;

        if (halted_reg || aborted_reg)
            res.status = ST_STOPPED;
        else if (cmd == CMD_DATA)
        begin
            if (!lpend_reg)
                res.status = ST_ORDER;
            else
            begin
                case (lkind_reg)
                    3'd0:    r = {{24{ldata[7]}}, ldata[7:0]};
                    3'd1:    r = {{16{ldata[15]}}, ldata[15:0]};
                    3'd4:    r = {24'd0, ldata[7:0]};
                    3'd5:    r = {16'd0, ldata[15:0]};
                    default: r = ldata;
                endcase
                lpend_next = 1'b0;
                want = 1'b1;
                rd   = ldest_reg;
            end
        end
        else if (lpend_reg)
            res.status = ST_ORDER;
        else
        begin
            upd = 1'b1;
            unique case (op)
                OP_LUI:
                begin
                    want = 1'b1;
                    r = {inst[31:12], 12'd0};
                end
                OP_AUIPC:
                begin
                    want = 1'b1;
                    r = pc_reg + {inst[31:12], 12'd0};
                end
                OP_IMM:
                begin
                    want = 1'b1;
                    case (f3)
                        3'd0: r = a + ii;
                        3'd2: r = {31'd0, $signed(a) < $signed(ii)};
                        3'd3: r = {31'd0, a < ii};
                        3'd4: r = a ^ ii;
                        3'd6: r = a | ii;
                        3'd7: r = a & ii;
                        3'd1:
                        begin
                            bad = (f7 != 7'h00);
                            r = a << rs2;
                        end
                        default:
                        begin
                            bad = (f7 != 7'h00) && (f7 != 7'h20);
                            r = (f7 == 7'h20) ? 32'($signed(a) >>> rs2) : a >> rs2;
                        end
                    endcase
                end
                OP_REG:
                begin
                    want = 1'b1;
                    if (f7 == 7'h20)
                    begin
                        if (f3 == 3'd0)
                            r = a - b;
                        else if (f3 == 3'd5)
                            r = 32'($signed(a) >>> b[4:0]);
                        else
                            bad = 1'b1;
                    end
                    else if (f7 == 7'h00)
                    begin
                        case (f3)
                            3'd0:    r = a + b;
                            3'd1:    r = a << b[4:0];
                            3'd2:    r = {31'd0, $signed(a) < $signed(b)};
                            3'd3:    r = {31'd0, a < b};
                            3'd4:    r = a ^ b;
                            3'd5:    r = a >> b[4:0];
                            3'd6:    r = a | b;
                            default: r = a & b;
                        endcase
                    end
                    else
                        bad = 1'b1;
                end
                OP_BRANCH:
                begin
                    case (f3)
                        3'd0:    taken = (a == b);
                        3'd1:    taken = (a != b);
                        3'd4:    taken = $signed(a) < $signed(b);
                        3'd5:    taken = !($signed(a) < $signed(b));
                        3'd6:    taken = a < b;
                        3'd7:    taken = a >= b;
                        default: bad = 1'b1;
                    endcase
                    if (taken)
                        npc = pc_reg + bi;
                end
                OP_JAL:
                begin
                    want = 1'b1;
                    r = npc;
                    npc = pc_reg + ji;
                end
                OP_JALR:
                begin
                    bad  = (f3 != 3'd0);
                    want = 1'b1;
                    r = npc;
                    npc = (a + ii) & ~32'd1;
                end
                OP_LOAD:
                begin
                    bad = (f3 == 3'd3) || (f3 > 3'd5);
                    res.mem_valid = 1'b1;
                    res.mem_size  = f3[1:0];
                    res.mem_addr  = a + ii;
                    lpend_next = 1'b1;
                    ldest_next = rd;
                    lkind_next = f3;
                end
                OP_STORE:
                begin
                    bad = (f3 > 3'd2);
                    res.mem_valid = 1'b1;
                    res.mem_write = 1'b1;
                    res.mem_size  = f3[1:0];
                    res.mem_addr  = a + si;
                    res.mem_wdata = b;
                end
                OP_FENCE:
                begin
                end
                OP_SYSTEM:
                begin
                    if (inst == INST_EBREAK)
                    begin
                        res.status  = ST_HALT;
                        halted_next = 1'b1;
                        upd = 1'b0;
                    end
                    else
                    begin
                        bad  = (f3[1:0] == 2'd0);
                        slot = csr_slot(inst[31:20]);
                        opnd = f3[2] ? {27'd0, rs1} : a;
                        old  = slot[3] ? csr_reg[slot[2:0]] : 32'd0;
                        csr_idx = slot[2:0];
                        case (f3[1:0])
                            2'd1:    csr_wval = opnd;
                            2'd2:    csr_wval = old | opnd;
                            default: csr_wval = old & ~opnd;
                        endcase
                        csr_we = slot[3] && ((f3[1:0] == 2'd1) || (rs1 != 5'd0));
                        want = 1'b1;
                        r = old;
                    end
                end
                default: bad = 1'b1;
            endcase
            if (bad)
            begin
                res = '0;
                res.status   = ST_INVALID;
                aborted_next = 1'b1;
                lpend_next   = lpend_reg;
                ldest_next   = ldest_reg;
                lkind_next   = lkind_reg;
                want   = 1'b0;
                csr_we = 1'b0;
                upd    = 1'b0;
            end
        end

        pc_next = upd ? npc : pc_reg;
        if (want && (rd != 5'd0))
        begin
            wr.en   = 1'b1;
            wr.idx  = rd;
            wr.data = r;
            res.rd_write = 1'b1;
            res.rd_index = rd;
            res.rd_value = r;
        end
        res.next_pc      = pc_next;
        res.load_waiting = lpend_next;
        if (!adv)
        begin
            wr.en  = 1'b0;
            csr_we = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg      <= RESET_PC;
            halted_reg  <= 1'b0;
            aborted_reg <= 1'b0;
            lpend_reg   <= 1'b0;
            ldest_reg   <= '0;
            lkind_reg   <= '0;
            for (int i = 0; i < NUM_CSRS; i++)
                csr_reg[i] <= '0;
        end
        else if (cfg_we)
            pc_reg <= cfg_pc;
        else if (adv)
        begin
            pc_reg      <= pc_next;
            halted_reg  <= halted_next;
            aborted_reg <= aborted_next;
            lpend_reg   <= lpend_next;
            ldest_reg   <= ldest_next;
            lkind_reg   <= lkind_next;
            if (csr_we)
                csr_reg[csr_idx] <= csr_wval;
        end
    end

endmodule

>>> rtl/rv32i_zicsr_instruction_executor_top.sv
// ----------------------------------------------------------------------------
// rv32i_zicsr_instruction_executor_top
// RV32I plus machine csr executor, one item per cycle unless the receiver stalls.
// ----------------------------------------------------------------------------
// usage
//  - slave stream: s_tuser selects an instruction item (0) or load data (1);
//    s_tdata carries the instruction word and the load data
//  - master stream: one result item per input item, in order; m_tuser holds
//    the status, m_tdata the pc, memory request and register write
//  - cfg channel loads the pc; write while idle
//  - path: an accepted item goes through the register file read, then
//    execute into the output register
//  - throughput: one item per cycle unless the receiver stalls, set by the register
//    file memory read port; a write-back is forwarded to the item read in the same cycle
//  - a stalled receiver holds the output register and the execute stage;
//    s_tready drops only when both are full
//  - reset: registers and csrs read zero, pc is 0x8000_0000, not halted
// ----------------------------------------------------------------------------
module rv32i_zicsr_instruction_executor_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // instruction[31:0], load_data[63:32]
    input  logic [0:0]   s_tuser,   // cmd[0]
    output logic         m_tvalid,
    input  logic         m_tready,
    // next_pc[31:0], mem_valid[32], mem_write[33], mem_size[35:34],
    // mem_addr[67:36], mem_wdata[99:68], rd_write[100], rd_index[105:101],
    // rd_value[137:106], load_waiting[138], zero[143:139]
    output logic [143:0] m_tdata,
    output logic [2:0]   m_tuser,   // status[2:0]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data
);
    import rv32x_pkg::*;

    localparam int AW = $clog2(NUM_REGS);

    logic        ex_valid_reg;
    logic        ex_cmd_reg;
    logic [31:0] ex_inst_reg, ex_ldata_reg;
    logic        out_valid_reg;
    res_t        out_reg;
    logic        accept, adv;
    logic [31:0] a, b;
    rf_wr_t      wr;
    res_t        res;

    // execute stage moves on when the output register is free or draining
    assign adv      = ex_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !ex_valid_reg || adv;
    assign accept   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    rv32x_regfile u_rf (
        .clk   (clk),
        .rst_n (rst_n),
        .rd_en (accept),
        .rs1   (s_tdata[15+AW-1:15]),
        .rs2   (s_tdata[20+AW-1:20]),
        .wr    (wr),
        .a     (a),
        .b     (b)
    );

    rv32x_exec u_exec (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .cmd    (ex_cmd_reg),
        .inst   (ex_inst_reg),
        .ldata  (ex_ldata_reg),
        .a      (a),
        .b      (b),
        .cfg_we (cfg_valid && cfg_ready),
        .cfg_pc (cfg_data),
        .wr     (wr),
        .res    (res)
    );

    // stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ex_cmd_reg   <= s_tuser[0];
            ex_inst_reg  <= s_tdata[31:0];
            ex_ldata_reg <= s_tdata[63:32];
        end
        if (adv)
            out_reg <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                ex_valid_reg <= 1'b1;
            else if (adv)
                ex_valid_reg <= 1'b0;
            if (adv)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {5'd0, out_reg.load_waiting, out_reg.rd_value, out_reg.rd_index,
                       out_reg.rd_write, out_reg.mem_wdata, out_reg.mem_addr,
                       out_reg.mem_size, out_reg.mem_write, out_reg.mem_valid,
                       out_reg.next_pc};

`ifndef SYNTHESIS
    a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (wr.idx != 5'd0))
        else $error("write to x0");
    a_stall_holds_ex: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !adv)
        else $error("execute advanced into a stalled output");
    a_notready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (ex_valid_reg && out_valid_reg))
        else $error("input stalled with a free stage");
    a_adv_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> m_tvalid)
        else $error("executed item lost");
`endif

endmodule
